// ===== design/ort_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ort_pkg - shared types and constants of the ordered route table
// Command codes, status codes and the per-cell entry and control words.
// ----------------------------------------------------------------------------
package ort_pkg;

  localparam int TableDepthDefault = 16;
  localparam int InterfaceCountDefault = 16;

  typedef enum logic [2:0] {
    CMD_LOOKUP = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_REBASE_NET  = 3'd3,
    CMD_REBASE_MASK = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] network;
    logic [31:0] mask;
    logic [3:0]  intf;
    logic [7:0]  metric;
    logic        host;
  } entry_t;

  // Control word broadcast to every cell for one command.
  typedef struct packed {
    logic        shift_in;    // insert at head, shift all toward tail
    logic        del;         // remove hit cell, pull tail side forward
    logic        rebase_net;
    logic        rebase_mask;
    logic [31:0] address;
    logic [31:0] net_mask;
    logic [3:0]  intf;
    logic [31:0] old_addr;
    logic [31:0] old_mask;
  } cell_ctl_t;

  // Per-cell match flags returned to the controller.
  typedef struct packed {
    logic lookup_hit;
    logic exact_hit;
    logic rebase_hit;
  } cell_match_t;

endpackage

// ===== design/ort_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ort_cell - one slot of the route chain
// Holds one entry, compares it against the command, and shifts or rewrites
// under the first-hit select from the controller.
// ----------------------------------------------------------------------------
module ort_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ort_pkg::cell_ctl_t  ctl,
  input  ort_pkg::entry_t     from_head,   // neighbor nearer the head
  input  ort_pkg::entry_t     from_tail,   // neighbor nearer the tail
  input  logic                sel,         // this cell is the first hit
  input  logic                after_sel,   // a nearer cell is the first hit
  output ort_pkg::entry_t     entry,
  output ort_pkg::cell_match_t match
);

  ort_pkg::entry_t entry_r, entry_nxt;

  assign entry = entry_r;

  always_comb begin
    match.lookup_hit = entry_r.valid &&
      ((ctl.address & entry_r.mask) == (entry_r.network & entry_r.mask));
    match.exact_hit  = entry_r.valid && entry_r.network == ctl.address &&
      entry_r.mask == ctl.net_mask;
    match.rebase_hit = entry_r.valid && !entry_r.host && entry_r.intf == ctl.intf &&
      ((entry_r.network & ctl.old_mask) == (ctl.old_addr & ctl.old_mask));
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift_in) begin
      entry_nxt = from_head;
    end else if (ctl.del && (sel || after_sel)) begin
      // pull the tail side forward over the removed slot
      entry_nxt = from_tail;
    end else if (ctl.rebase_net && sel) begin
      entry_nxt.network = ctl.address;
    end else if (ctl.rebase_mask && sel) begin
      entry_nxt.mask = ctl.net_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// ===== design/ordered_route_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_route_table - ordered IPv4 route table with default route
// A chain of entry cells, newest at the head, plus a single default slot.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_* with a command word and pulse start while busy is low; the
//   word is taken at that clock edge. busy stays low, so one command may be
//   issued every cycle.
//   In the cycle after acceptance the result word is on out_* with out_valid
//   high for exactly that cycle. It reflects the table before the command;
//   the table update lands at the same edge, so the next command sees it.
//   Throughput is one command per cycle, set by the parallel compare in every
//   cell and a priority pick of the first hit.
//   Every cell compares, and the chain shifts by one slot on add or delete.
//   The receiver cannot stall: out_valid words must be taken when shown.
//   Reset (rst_n low, synchronous) empties the chain and the default slot
//   and drops any pending result.
// ----------------------------------------------------------------------------
module ordered_route_table #(
  parameter int TABLE_DEPTH     = ort_pkg::TableDepthDefault,
  parameter int INTERFACE_COUNT = ort_pkg::InterfaceCountDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_address,
  input  logic [31:0] in_net_mask,
  input  logic [31:0] in_gateway,
  input  logic [3:0]  in_interface_id,
  input  logic [7:0]  in_metric,
  input  logic        in_gateway_flag,
  input  logic        in_host_flag,
  input  logic [31:0] in_old_if_address,
  input  logic [31:0] in_old_if_mask,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_route_gateway,
  output logic [3:0]  out_route_interface,
  output logic [7:0]  out_route_metric,
  output logic        out_via_default,
  output logic        out_entry_changed
);

  ort_pkg::cell_ctl_t   ctl;
  ort_pkg::entry_t      cell_entry [TABLE_DEPTH];
  ort_pkg::entry_t      head_in    [TABLE_DEPTH];
  ort_pkg::entry_t      tail_in    [TABLE_DEPTH];
  ort_pkg::cell_match_t cell_match [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit_vec, sel_vec, after_vec;

  logic        def_valid_r, def_valid_nxt;
  logic [31:0] def_network_r, def_network_nxt;
  logic [31:0] def_mask_r, def_mask_nxt;
  logic [31:0] def_gateway_r, def_gateway_nxt;
  logic [3:0]  def_intf_r, def_intf_nxt;
  logic [7:0]  def_metric_r, def_metric_nxt;

  logic        out_valid_r;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] gw_r, gw_nxt;
  logic [3:0]  rif_r, rif_nxt;
  logic [7:0]  rmet_r, rmet_nxt;
  logic        viadef_r, viadef_nxt;
  logic        changed_r, changed_nxt;

  logic accept, ifc_ok, any_hit, def_match;
  ort_pkg::entry_t hit_entry, new_entry;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign ifc_ok = 32'(in_interface_id) < 32'(INTERFACE_COUNT);

  always_comb begin
    new_entry.valid   = 1'b1;
    new_entry.network = in_address;
    new_entry.mask    = in_net_mask;
    new_entry.intf    = in_interface_id;
    new_entry.metric  = in_metric;
    new_entry.host    = in_host_flag;
  end

  assign def_match = def_valid_r && def_network_r == in_address &&
                     def_mask_r == in_net_mask;

  // Pick which compare drives the first-hit chain.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      case (in_command)
        ort_pkg::CMD_LOOKUP: hit_vec[i] = cell_match[i].lookup_hit;
        ort_pkg::CMD_DELETE: hit_vec[i] = cell_match[i].exact_hit;
        default:             hit_vec[i] = cell_match[i].rebase_hit;
      endcase
    end
  end

  // First-hit select rippled down the chain.
  always_comb begin
    after_vec[0] = 1'b0;
    sel_vec[0]   = hit_vec[0];
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      after_vec[i] = after_vec[i-1] || sel_vec[i-1];
      sel_vec[i]   = hit_vec[i] && !after_vec[i];
    end
  end

  assign any_hit = |hit_vec;

  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (sel_vec[i]) hit_entry = cell_entry[i];
    end
  end

  always_comb begin
    ctl.shift_in    = accept && in_command == ort_pkg::CMD_ADD && ifc_ok &&
                      !in_gateway_flag && !cell_entry[TABLE_DEPTH-1].valid;
    ctl.del         = accept && in_command == ort_pkg::CMD_DELETE && ifc_ok &&
                      !def_match;
    ctl.rebase_net  = accept && in_command == ort_pkg::CMD_REBASE_NET && ifc_ok;
    ctl.rebase_mask = accept && in_command == ort_pkg::CMD_REBASE_MASK && ifc_ok;
    ctl.address     = in_address;
    ctl.net_mask    = in_net_mask;
    ctl.intf        = in_interface_id;
    ctl.old_addr    = in_old_if_address;
    ctl.old_mask    = in_old_if_mask;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign head_in[g] = new_entry;
    end else begin : g_mid
      assign head_in[g] = cell_entry[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign tail_in[g] = '0;
    end else begin : g_body
      assign tail_in[g] = cell_entry[g+1];
    end
    ort_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .from_head (head_in[g]),
      .from_tail (tail_in[g]),
      .sel       (sel_vec[g]),
      .after_sel (after_vec[g]),
      .entry     (cell_entry[g]),
      .match     (cell_match[g])
    );
  end

  // Default slot and result word.
  always_comb begin
    def_valid_nxt   = def_valid_r;
    def_network_nxt = def_network_r;
    def_mask_nxt    = def_mask_r;
    def_gateway_nxt = def_gateway_r;
    def_intf_nxt    = def_intf_r;
    def_metric_nxt  = def_metric_r;
    status_nxt  = ort_pkg::ST_OK;
    gw_nxt      = '0;
    rif_nxt     = '0;
    rmet_nxt    = '0;
    viadef_nxt  = 1'b0;
    changed_nxt = 1'b0;
    case (in_command)
      ort_pkg::CMD_LOOKUP: begin
        if (any_hit) begin
          rif_nxt  = hit_entry.intf;
          rmet_nxt = hit_entry.metric;
        end else if (def_valid_r) begin
          gw_nxt     = def_gateway_r;
          rif_nxt    = def_intf_r;
          rmet_nxt   = def_metric_r;
          viadef_nxt = 1'b1;
        end else begin
          status_nxt = ort_pkg::ST_NOT_FOUND;
        end
      end
      ort_pkg::CMD_ADD: begin
        if (!ifc_ok) begin
          status_nxt = ort_pkg::ST_NOT_FOUND;
        end else if (in_gateway_flag) begin
          def_valid_nxt   = 1'b1;
          def_network_nxt = in_address;
          def_mask_nxt    = in_net_mask;
          def_gateway_nxt = in_gateway;
          def_intf_nxt    = in_interface_id;
          def_metric_nxt  = in_metric;
        end else if (cell_entry[TABLE_DEPTH-1].valid) begin
          status_nxt = ort_pkg::ST_FULL;
        end
      end
      ort_pkg::CMD_DELETE: begin
        if (!ifc_ok) begin
          status_nxt = ort_pkg::ST_NOT_FOUND;
        end else if (def_match) begin
          def_valid_nxt   = 1'b0;
          def_network_nxt = '0;
          def_mask_nxt    = '0;
          def_gateway_nxt = '0;
          def_intf_nxt    = '0;
          def_metric_nxt  = '0;
        end else if (!any_hit) begin
          status_nxt = ort_pkg::ST_NOT_FOUND;
        end
      end
      ort_pkg::CMD_REBASE_NET, ort_pkg::CMD_REBASE_MASK: begin
        if (ifc_ok && any_hit) begin
          changed_nxt = 1'b1;
        end else begin
          status_nxt = ort_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        status_nxt = ort_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_valid_r   <= 1'b0;
      def_network_r <= '0;
      def_mask_r    <= '0;
      def_gateway_r <= '0;
      def_intf_r    <= '0;
      def_metric_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        def_valid_r   <= def_valid_nxt;
        def_network_r <= def_network_nxt;
        def_mask_r    <= def_mask_nxt;
        def_gateway_r <= def_gateway_nxt;
        def_intf_r    <= def_intf_nxt;
        def_metric_r  <= def_metric_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      gw_r      <= gw_nxt;
      rif_r     <= rif_nxt;
      rmet_r    <= rmet_nxt;
      viadef_r  <= viadef_nxt;
      changed_r <= changed_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_route_gateway   = gw_r;
  assign out_route_interface = rif_r;
  assign out_route_metric    = rmet_r;
  assign out_via_default     = viadef_r;
  assign out_entry_changed   = changed_r;

`ifndef NO_ASSERTIONS
  // valid entries stay packed from the head
  generate
    for (genvar a = 1; a < TABLE_DEPTH; a++) begin : g_chk
      a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        cell_entry[a].valid |-> cell_entry[a-1].valid)
        else $error("route chain has a hole");
    end
  endgenerate

  a_one_sel: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(sel_vec))
    else $error("more than one first hit");

  a_full_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ort_pkg::ST_FULL |-> cell_entry[TABLE_DEPTH-1].valid)
    else $error("full reported with free slot");

  a_def_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_via_default |-> out_status == ort_pkg::ST_OK)
    else $error("default answer with error status");
`endif

endmodule
